@@ design/pcmi_pkg.sv @@
`timescale 1ns / 1ps
package pcmi_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
   localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
   localparam int COLOR_W         = 32;
   localparam int CHAN_W          = 8;
   localparam int SQ_W            = 2 * CHAN_W;
   localparam int DIST_W          = 18;

   // Operation codes
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Outcome codes
   localparam logic [2:0] OC_MATCH    = 3'd0;
   localparam logic [2:0] OC_INSERTED = 3'd1;
   localparam logic [2:0] OC_NEAREST  = 3'd2;
   localparam logic [2:0] OC_WRITTEN  = 3'd3;
   localparam logic [2:0] OC_IGNORED  = 3'd4;
   localparam logic [2:0] OC_CLEARED  = 3'd5;

   // Palette write port
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [COLOR_W-1:0] data;
   } mem_wr_type;

   // Registered output of the distance unit
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [SQ_W-1:0]  sq_r;
      logic [SQ_W-1:0]  sq_g;
      logic [SQ_W-1:0]  sq_b;
   } dist_out_type;

endpackage

@@ design/pcmi_palette_mem.sv @@
`timescale 1ns / 1ps
module pcmi_palette_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  pcmi_pkg::mem_wr_type          wr,
   input  logic                          rd_en,
   input  logic [pcmi_pkg::IDX_W-1:0]    rd_addr,
   output logic [pcmi_pkg::COLOR_W-1:0]  rd_data
);
   import pcmi_pkg::*;

   logic [COLOR_W-1:0]         mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] entry_valid_ff;
   logic [COLOR_W-1:0]         rdata_ff;
   logic                       rvalid_ff;

   // Store color words
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Track written entries; clear empties the whole palette at once
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         entry_valid_ff <= '0;
         rvalid_ff      <= 1'b0;
      end else begin
         if (wr.en) begin
            entry_valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= entry_valid_ff[rd_addr];
         end
      end
   end

   // Entries never written since clear read as zero
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

@@ design/pcmi_dist_unit.sv @@
`timescale 1ns / 1ps
module pcmi_dist_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [pcmi_pkg::IDX_W-1:0]    in_idx,
   input  logic [pcmi_pkg::COLOR_W-1:0]  color_a,
   input  logic [pcmi_pkg::COLOR_W-1:0]  color_b,
   output pcmi_pkg::dist_out_type        dout
);
   import pcmi_pkg::*;

   logic              s1_valid_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [CHAN_W-1:0] d_r_ff, d_g_ff, d_b_ff;
   logic [CHAN_W-1:0] d_r_in, d_g_in, d_b_in;
   logic              s2_valid_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // Per-channel absolute differences, alpha dropped
   always_comb begin
      d_r_in = abs_diff(color_a[7:0],   color_b[7:0]);
      d_g_in = abs_diff(color_a[15:8],  color_b[15:8]);
      d_b_in = abs_diff(color_a[23:16], color_b[23:16]);
   end

   // Advance valid tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Difference stage, then square stage
   always_ff @(posedge clock) begin
      s1_idx_ff <= in_idx;
      d_r_ff    <= d_r_in;
      d_g_ff    <= d_g_in;
      d_b_ff    <= d_b_in;
      s2_idx_ff <= s1_idx_ff;
      sq_r_ff   <= SQ_W'(d_r_ff) * SQ_W'(d_r_ff);
      sq_g_ff   <= SQ_W'(d_g_ff) * SQ_W'(d_g_ff);
      sq_b_ff   <= SQ_W'(d_b_ff) * SQ_W'(d_b_ff);
   end

   assign dout.valid = s2_valid_ff;
   assign dout.idx   = s2_idx_ff;
   assign dout.sq_r  = sq_r_ff;
   assign dout.sq_g  = sq_g_ff;
   assign dout.sq_b  = sq_b_ff;

endmodule

@@ design/palette_color_match_insert_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    operation, color_value, entry_index
// rsp_      out        rsp_valid/stall    color_index, outcome, nearest_distance
//
// An add scans entries 1 .. count-1, one palette read per cycle through the
// single memory read port, feeding the distance pipeline (difference stage,
// then square stage). Write, clear and ignored transactions pass from decode
// straight to finish. Reset sets the count to one and clears the entry valid
// bits. req_stall is high while a transaction is in work; a stalled result
// holds in the output register while the next request is accepted.
module palette_color_match_insert_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_color_value,
   input  logic [7:0]  req_entry_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_color_index,
   output logic [2:0]  rsp_outcome,
   output logic [17:0] rsp_nearest_distance
);
   import pcmi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESOLVE,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         op_ff, op_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [7:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic [1:0]         drain_ff, drain_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [7:0]         res_idx_ff, res_idx_in;
   logic [2:0]         res_oc_ff, res_oc_in;
   logic [DIST_W-1:0]  res_dist_ff, res_dist_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_idx_ff, rsp_idx_in;
   logic [2:0]         rsp_oc_ff, rsp_oc_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;

   mem_wr_type         mem_wr;
   logic               mem_clear;
   logic               mem_rd_en;
   logic [COLOR_W-1:0] mem_rd_data;
   dist_out_type       dist_out;
   logic [DIST_W-1:0]  dist_sum;
   logic [IDX_W-1:0]   last_idx;
   logic               full;
   logic               write_ok;

   pcmi_palette_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .wr      (mem_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_addr_ff),
      .rd_data (mem_rd_data)
   );

   pcmi_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_valid_ff),
      .in_idx   (rd_idx_ff),
      .color_a  (mem_rd_data),
      .color_b  (color_ff),
      .dout     (dist_out)
   );

   assign dist_sum = DIST_W'(dist_out.sq_r) + DIST_W'(dist_out.sq_g) +
                     DIST_W'(dist_out.sq_b);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign full     = (count_ff == CNT_W'(PALETTE_ENTRIES));
   assign write_ok = (idx_ff != 8'd0) && ({1'b0, idx_ff} < 9'(PALETTE_ENTRIES));

   // Sequence one transaction
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      color_in     = color_ff;
      idx_in       = idx_ff;
      scan_addr_in = scan_addr_ff;
      drain_in     = drain_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = scan_addr_ff;
      found_in     = found_ff;
      match_idx_in = match_idx_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      res_idx_in   = res_idx_ff;
      res_oc_in    = res_oc_ff;
      res_dist_in  = res_dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_oc_in    = rsp_oc_ff;
      rsp_dist_in  = rsp_dist_ff;
      mem_wr.en    = 1'b0;
      mem_wr.addr  = IDX_W'(idx_ff);
      mem_wr.data  = color_ff;
      mem_clear    = 1'b0;
      mem_rd_en    = 1'b0;

      // Drop a delivered result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Keep the first exact match
      if (rd_valid_ff && !found_ff && (mem_rd_data == color_ff)) begin
         found_in     = 1'b1;
         match_idx_in = rd_idx_ff;
      end

      // Keep the nearest entry, lowest index on ties
      if (dist_out.valid && (dist_sum < best_dist_ff)) begin
         best_dist_in = dist_sum;
         best_idx_in  = dist_out.idx;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               color_in = req_color_value;
               idx_in   = req_entry_index;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_idx_in  = 8'd0;
            res_dist_in = '0;
            res_oc_in   = OC_IGNORED;
            state_in    = ST_FINISH;
            case (op_ff)
               OP_ADD: begin
                  found_in     = 1'b0;
                  best_dist_in = '1;
                  best_idx_in  = IDX_W'(1);
                  scan_addr_in = IDX_W'(1);
                  state_in     = (count_ff > CNT_W'(1)) ? ST_SCAN : ST_RESOLVE;
               end
               OP_WRITE: begin
                  if (write_ok) begin
                     mem_wr.en = 1'b1;
                     res_oc_in = OC_WRITTEN;
                     if ({1'b0, idx_ff} >= 9'(count_ff)) begin
                        count_in = CNT_W'({1'b0, idx_ff} + 9'd1);
                     end
                  end
               end
               OP_CLEAR: begin
                  mem_clear = 1'b1;
                  count_in  = CNT_W'(1);
                  res_oc_in = OC_CLEARED;
               end
               default: begin
                  res_oc_in = OC_IGNORED;
               end
            endcase
         end
         ST_SCAN: begin
            mem_rd_en   = 1'b1;
            rd_valid_in = 1'b1;
            if (scan_addr_ff == last_idx) begin
               drain_in = 2'd2;
               state_in = ST_DRAIN;
            end else begin
               scan_addr_in = scan_addr_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_ff == 2'd0) begin
               state_in = ST_RESOLVE;
            end else begin
               drain_in = drain_ff - 2'd1;
            end
         end
         ST_RESOLVE: begin
            res_dist_in = '0;
            state_in    = ST_FINISH;
            if (found_ff) begin
               res_idx_in = 8'(match_idx_ff);
               res_oc_in  = OC_MATCH;
            end else if (!full) begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = IDX_W'(count_ff);
               res_idx_in  = 8'(count_ff);
               res_oc_in   = OC_INSERTED;
               count_in    = count_ff + CNT_W'(1);
            end else begin
               res_idx_in  = 8'(best_idx_ff);
               res_oc_in   = OC_NEAREST;
               res_dist_in = best_dist_ff;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = res_idx_ff;
               rsp_oc_in    = res_oc_ff;
               rsp_dist_in  = res_dist_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(1);
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         color_ff     <= color_in;
         idx_ff       <= idx_in;
         scan_addr_ff <= scan_addr_in;
         drain_ff     <= drain_in;
         rd_idx_ff    <= rd_idx_in;
         found_ff     <= found_in;
         match_idx_ff <= match_idx_in;
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
         res_idx_ff   <= res_idx_in;
         res_oc_ff    <= res_oc_in;
         res_dist_ff  <= res_dist_in;
         rsp_idx_ff   <= rsp_idx_in;
         rsp_oc_ff    <= rsp_oc_in;
         rsp_dist_ff  <= rsp_dist_in;
      end
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_color_index      = rsp_idx_ff;
   assign rsp_outcome          = rsp_oc_ff;
   assign rsp_nearest_distance = rsp_dist_ff;

endmodule
